>>> sv/stack_allocator_macros.svh
// Assertion macros used by the stack allocator RTL.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef STACK_ALLOCATOR_MACROS_SVH
`define STACK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sa_pkg.sv
// Types and fixed constants for the stack allocator.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package sa_pkg;

    // Fixed field widths.
    localparam int OFF_W     = 13;
    localparam int PAD_W     = 9;
    localparam int ALIGN_W   = 9;
    localparam int ADDR_W    = 32;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARENA_SIZE   = 8'd1;

    // Reset value of the usable arena size.
    localparam logic [OFF_W-1:0] ARENA_SIZE_RESET = 13'd4096;

    // Request kinds; the fourth code is a no-op.
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_READ = 3'b100
    } sa_state_t;

endpackage

>>> sv/sa_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; the read data holds until the next read enable.
`timescale 1ns / 1ps

module sa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/stack_allocator.sv
// Stack allocator: LIFO arena allocator with padding headers kept in a synchronous RAM.
// Allocate, clear, no-op and out-of-range free requests run two steps (accept, execute);
// a live free runs three (accept, header read, rewind) for the registered header RAM read.
// The result is registered at the last step; a held result stalls that step.
// Reset (aresetn low at a clock edge) clears offset, peak and handshakes and resets configuration;
// the header RAM is not cleared and no clearing pass runs.
`timescale 1ns / 1ps
`include "stack_allocator_macros.svh"

module stack_allocator
    import sa_pkg::*;
#(
    parameter int ARENA_BYTES  = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int MAX_ALIGN    = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: request_size[12:0], alignment[21:13], block_address[53:22], zero pad
    input  logic [S_DATA_W-1:0]  s_tdata,
    // s_tuser: kind[1:0]
    input  logic [KIND_W-1:0]    s_tuser,
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: granted_address[31:0], used_bytes[44:32], peak_bytes[57:45], zero pad
    output logic [M_DATA_W-1:0]  m_tdata,
    // m_tuser: failed[0]
    output logic                 m_tuser
);

    localparam int AW     = $clog2(ARENA_BYTES);
    localparam int PADC_W = PAD_W + 1;
    localparam int END_W  = OFF_W + 2;

    // Control registers.
    sa_state_t            state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OFF_W-1:0]     top_reg, top_next;
    logic [OFF_W-1:0]     peak_reg, peak_next;
    logic [ADDR_W-1:0]    base_reg;
    logic [OFF_W-1:0]     arena_size_reg;

    // Request and result payload registers.
    kind_t                kind_reg, kind_next;
    logic [OFF_W-1:0]     size_reg, size_next;
    logic [ALIGN_W-1:0]   align_reg, align_next;
    logic [ADDR_W-1:0]    blk_reg, blk_next;
    logic [OFF_W-1:0]     rel_reg, rel_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic [ADDR_W-1:0]    granted_reg, granted_next;
    logic                 failed_reg, failed_next;

    // Datapath signals.
    logic                 out_free;
    logic [OFF_W-1:0]     limit;
    logic [ALIGN_W-1:0]   align_mask;
    logic                 align_valid;
    logic [ADDR_W-1:0]    cur_addr;
    logic [ALIGN_W-1:0]   pad_base;
    logic [PADC_W-1:0]    pad_need;
    logic [PADC_W-1:0]    pad_round;
    logic [PADC_W-1:0]    pad_calc;
    logic [END_W-1:0]     alloc_end;
    logic [END_W-1:0]     hdr_wr;
    logic                 alloc_fits;
    logic [ADDR_W-1:0]    rel_addr;
    logic                 free_hit;
    logic [OFF_W-1:0]     hdr_rd;
    logic [PAD_W-1:0]     pad_rd;

    // Header RAM ports.
    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [PAD_W-1:0]     ram_rdata;

    sa_ram #(
        .WIDTH (PAD_W),
        .DEPTH (ARENA_BYTES)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pad_calc[PAD_W-1:0]),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration is taken in any cycle.
    assign cfg_ready = 1'b1;

    // Usable limit, capped at the built arena depth.
    assign limit = (arena_size_reg > ARENA_BYTES) ? OFF_W'(ARENA_BYTES) : arena_size_reg;

    // Alignment check and padding up to the next aligned address past the header.
    assign align_mask  = align_reg - ALIGN_W'(1);
    assign align_valid = (align_reg == '0) ||
                         ((align_reg <= MAX_ALIGN) && ((align_reg & align_mask) == '0));
    assign cur_addr    = base_reg + ADDR_W'(top_reg);
    assign pad_base    = (align_reg - (cur_addr[ALIGN_W-1:0] & align_mask)) & align_mask;
    assign pad_need    = PADC_W'(HEADER_BYTES) - {1'b0, pad_base};
    assign pad_round   = (pad_need + {1'b0, align_mask}) & ~{1'b0, align_mask};

    always_comb begin
        if (align_reg == '0) begin
            pad_calc = PADC_W'(HEADER_BYTES);
        end else if ({1'b0, pad_base} < PADC_W'(HEADER_BYTES)) begin
            pad_calc = {1'b0, pad_base} + pad_round;
        end else begin
            pad_calc = {1'b0, pad_base};
        end
    end

    // End of the new block and the header slot just below the granted address.
    assign alloc_end  = END_W'(top_reg) + END_W'(size_reg) + END_W'(pad_calc);
    assign alloc_fits = alloc_end <= END_W'(limit);
    assign hdr_wr     = END_W'(top_reg) + END_W'(pad_calc) - END_W'(HEADER_BYTES);
    assign ram_waddr  = AW'(hdr_wr);

    // Free: position of the block relative to the arena start.
    assign rel_addr  = blk_reg - base_reg;
    assign free_hit  = (rel_addr >= ADDR_W'(HEADER_BYTES)) && (rel_addr <= ADDR_W'(top_reg));
    assign hdr_rd    = rel_addr[OFF_W-1:0] - OFF_W'(HEADER_BYTES);
    assign ram_raddr = AW'(hdr_rd);
    assign pad_rd    = rd_ok_reg ? ram_rdata : '0;

    // The result slot can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer: reads and writes of the header RAM come from different request kinds, so
    // a write and a later read of the same entry never overlap.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        top_next     = top_reg;
        peak_next    = peak_reg;
        kind_next    = kind_reg;
        size_next    = size_reg;
        align_next   = align_reg;
        blk_next     = blk_reg;
        rel_next     = rel_reg;
        rd_ok_next   = rd_ok_reg;
        granted_next = granted_reg;
        failed_next  = failed_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = kind_t'(s_tuser);
                    size_next  = s_tdata[12:0];
                    align_next = s_tdata[21:13];
                    blk_next   = s_tdata[53:22];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (kind_reg)
                    KIND_ALLOC: begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            state_next   = ST_IDLE;
                            if (align_valid && alloc_fits) begin
                                ram_we       = hdr_wr < ARENA_BYTES;
                                granted_next = cur_addr + ADDR_W'(pad_calc);
                                failed_next  = 1'b0;
                                top_next     = alloc_end[OFF_W-1:0];
                                if (alloc_end[OFF_W-1:0] > peak_reg) begin
                                    peak_next = alloc_end[OFF_W-1:0];
                                end
                            end else begin
                                granted_next = '0;
                                failed_next  = 1'b1;
                            end
                        end
                    end
                    KIND_FREE: begin
                        if (free_hit) begin
                            // Fetch the header; the rewind happens once it returns.
                            ram_re     = hdr_rd < ARENA_BYTES;
                            rd_ok_next = hdr_rd < ARENA_BYTES;
                            rel_next   = rel_addr[OFF_W-1:0];
                            state_next = ST_READ;
                        end else if (out_free) begin
                            m_valid_next = 1'b1;
                            granted_next = '0;
                            failed_next  = 1'b0;
                            state_next   = ST_IDLE;
                        end
                    end
                    KIND_CLEAR: begin
                        if (out_free) begin
                            top_next     = '0;
                            peak_next    = '0;
                            m_valid_next = 1'b1;
                            granted_next = '0;
                            failed_next  = 1'b0;
                            state_next   = ST_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            granted_next = '0;
                            failed_next  = 1'b0;
                            state_next   = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_READ: begin
                if (out_free) begin
                    // A padding larger than the block position rewinds to zero.
                    if (OFF_W'(pad_rd) > rel_reg) begin
                        top_next = '0;
                    end else begin
                        top_next = rel_reg - OFF_W'(pad_rd);
                    end
                    m_valid_next = 1'b1;
                    granted_next = '0;
                    failed_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            top_reg        <= '0;
            peak_reg       <= '0;
            base_reg       <= '0;
            arena_size_reg <= ARENA_SIZE_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            top_reg     <= top_next;
            peak_reg    <= peak_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BASE_ADDRESS: base_reg       <= cfg_data;
                    CFG_ARENA_SIZE:   arena_size_reg <= cfg_data[OFF_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        size_reg    <= size_next;
        align_reg   <= align_next;
        blk_reg     <= blk_next;
        rel_reg     <= rel_next;
        rd_ok_reg   <= rd_ok_next;
        granted_reg <= granted_next;
        failed_reg  <= failed_next;
    end

    // Offset and peak change only when a result is loaded, so they follow the held result.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = failed_reg;
    assign m_tdata  = {6'b0, peak_reg, top_reg, granted_reg};

    // The offset in use never passes the recorded peak.
    `SA_ASSERT_NOW(a_top_le_peak, 1'b1, top_reg <= peak_reg, "offset above peak")
    // Header writes and reads never share a cycle.
    `SA_ASSERT_NOW(a_ram_excl, ram_we, !ram_re, "header RAM read and write overlap")
    // A header read is always followed by the rewind state.
    `SA_ASSERT_NEXT(a_read_then_rewind, ram_re, state_reg == ST_READ, "header read lost")

endmodule
